@@ src/qtg_pkg.sv @@
// Shared constants and types for the quintic trajectory generator.
`timescale 1ns / 1ps
package qtg_pkg;
	localparam int CFG_W        = 32;
	localparam int IDX_W        = 3;
	localparam int QUO_BITS     = 32;
	localparam int HORNER_CELLS = 5;
	localparam int LANES        = 3;

	localparam int LANE_POS = 0;
	localparam int LANE_SPD = 1;
	localparam int LANE_ACC = 2;

	localparam logic [IDX_W-1:0] REG_DURATION   = 3'd0;
	localparam logic [IDX_W-1:0] REG_START_POS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_END_POS    = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_VEL  = 3'd3;
	localparam logic [IDX_W-1:0] REG_END_VEL    = 3'd4;
	localparam logic [IDX_W-1:0] REG_START_ACC  = 3'd5;
	localparam logic [IDX_W-1:0] REG_END_ACC    = 3'd6;

	localparam logic [QUO_BITS-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [QUO_BITS-1:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic hi;
		logic lo;
	} sat_t;
endpackage

@@ src/qtg_ifs.sv @@
// Handshake channels: sample tick in, trajectory word out.
`timescale 1ns / 1ps
interface qtg_time_if #(parameter int TIME_BITS = 10) ();
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] sample_time;
	modport source (output valid, output sample_time, input ready);
	modport sink (input valid, input sample_time, output ready);
endinterface

interface qtg_traj_if ();
	logic        valid;
	logic        ready;
	logic [31:0] position;
	logic [31:0] speed;
	logic [31:0] accel_out;
	logic        overflow;
	modport source (output valid, output position, output speed, output accel_out,
		output overflow, input ready);
	modport sink (input valid, input position, input speed, input accel_out,
		input overflow, output ready);
endinterface

@@ src/qtg_coef.sv @@
// Segment registers and the sequencer that turns them into polynomial coefficients.
`timescale 1ns / 1ps
module qtg_coef #(
	parameter int TIME_BITS = 10,
	parameter int W         = 118,
	parameter int DW        = 51
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [qtg_pkg::IDX_W-1:0] wr_index,
	input  logic [qtg_pkg::CFG_W-1:0] wr_data,
	output logic busy,
	output logic [qtg_pkg::HORNER_CELLS:0][qtg_pkg::LANES-1:0][W-1:0] coef,
	output logic [DW-1:0] den
);
	import qtg_pkg::*;

	localparam int BW      = CFG_W + 8;
	localparam int TGT_C5  = 0;
	localparam int TGT_C4  = 1;
	localparam int TGT_C3  = 2;
	localparam int TGT_C2  = 3;
	localparam int TGT_C1  = 4;
	localparam int TGT_C0  = 5;
	localparam int TGT_DEN = 6;
	localparam int TGTS    = 7;
	localparam logic [2:0] STEP_FIRST  = 3'd0;
	localparam logic [2:0] STEP_DERIVE = 3'd6;

	logic [TIME_BITS-1:0]    dur_q;
	logic signed [CFG_W-1:0] p0_q, p1_q, v0_q, v1_q, a0_q, a1_q;
	logic [2:0]              step_q;
	logic                    busy_q;
	logic signed [W-1:0]     acc_q [TGTS];
	logic [HORNER_CELLS:0][LANES-1:0][W-1:0] coef_q;
	logic [DW-1:0]           den_q;

	logic [TIME_BITS-1:0]    t_eff;
	logic [2:0]              pw;
	logic signed [BW-1:0]    dp, dv, da, p0x, v0x, a0x;
	logic signed [BW-1:0]    base [TGTS];
	logic signed [W-1:0]     half;

	assign t_eff = (dur_q == '0) ? TIME_BITS'(1) : dur_q;
	assign pw    = 3'd5 - step_q;
	assign busy  = busy_q;
	assign coef  = coef_q;
	assign den   = den_q;
	assign half  = acc_q[TGT_DEN] >>> 1;

	always_comb begin
		p0x = BW'(p0_q);
		v0x = BW'(v0_q);
		a0x = BW'(a0_q);
		dp  = BW'(p1_q) - BW'(p0_q);
		dv  = BW'(v1_q) - BW'(v0_q);
		da  = BW'(a1_q) - BW'(a0_q);
		for (int j = 0; j < TGTS; j++) begin
			base[j] = '0;
		end
		// coefficient of T^pw for every target
		case (pw)
			3'd0: begin
				base[TGT_C5] = dp * 12;
			end
			3'd1: begin
				base[TGT_C5] = -(v0x * 12) - dv * 6;
				base[TGT_C4] = -(dp * 30);
			end
			3'd2: begin
				base[TGT_C5] = da;
				base[TGT_C4] = v0x * 30 + dv * 14;
				base[TGT_C3] = dp * 20;
			end
			3'd3: begin
				base[TGT_C4] = a0x - da * 2;
				base[TGT_C3] = -(v0x * 20) - dv * 8;
			end
			3'd4: begin
				base[TGT_C3] = da - a0x * 2;
			end
			3'd5: begin
				base[TGT_C2]  = a0x;
				base[TGT_C1]  = v0x * 2;
				base[TGT_C0]  = p0x * 2 + 1;
				base[TGT_DEN] = BW'(2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= TIME_BITS'(1);
			p0_q  <= '0;
			p1_q  <= '0;
			v0_q  <= '0;
			v1_q  <= '0;
			a0_q  <= '0;
			a1_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_DURATION:  dur_q <= wr_data[TIME_BITS-1:0];
				REG_START_POS: p0_q  <= wr_data;
				REG_END_POS:   p1_q  <= wr_data;
				REG_START_VEL: v0_q  <= wr_data;
				REG_END_VEL:   v1_q  <= wr_data;
				REG_START_ACC: a0_q  <= wr_data;
				REG_END_ACC:   a1_q  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= STEP_FIRST;
		end else if (wr_en) begin
			busy_q <= 1'b1;
			step_q <= STEP_FIRST;
		end else if (busy_q) begin
			if (step_q == STEP_DERIVE) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Horner in T: one power per step for all targets
	always_ff @(posedge clk) begin
		if (busy_q && step_q != STEP_DERIVE) begin
			for (int j = 0; j < TGTS; j++) begin
				if (step_q == STEP_FIRST) begin
					acc_q[j] <= W'(base[j]);
				end else begin
					acc_q[j] <= W'(acc_q[j] * $signed({1'b0, t_eff})) + W'(base[j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q == STEP_DERIVE) begin
			den_q <= acc_q[TGT_DEN][DW-1:0];
			coef_q[0][LANE_POS] <= acc_q[TGT_C5];
			coef_q[0][LANE_SPD] <= '0;
			coef_q[0][LANE_ACC] <= '0;
			coef_q[1][LANE_POS] <= acc_q[TGT_C4];
			coef_q[1][LANE_SPD] <= acc_q[TGT_C5] * 5;
			coef_q[1][LANE_ACC] <= '0;
			coef_q[2][LANE_POS] <= acc_q[TGT_C3];
			coef_q[2][LANE_SPD] <= acc_q[TGT_C4] * 4;
			coef_q[2][LANE_ACC] <= acc_q[TGT_C5] * 20;
			coef_q[3][LANE_POS] <= acc_q[TGT_C2];
			coef_q[3][LANE_SPD] <= acc_q[TGT_C3] * 3;
			coef_q[3][LANE_ACC] <= acc_q[TGT_C4] * 12;
			coef_q[4][LANE_POS] <= acc_q[TGT_C1];
			coef_q[4][LANE_SPD] <= acc_q[TGT_C2] * 2;
			coef_q[4][LANE_ACC] <= acc_q[TGT_C3] * 6;
			coef_q[5][LANE_POS] <= acc_q[TGT_C0];
			coef_q[5][LANE_SPD] <= acc_q[TGT_C1] + half;
			coef_q[5][LANE_ACC] <= acc_q[TGT_C2] * 2 + half;
		end
	end
endmodule

@@ src/qtg_horner_cell.sv @@
// One Horner step in the sample tick for the position, speed and accel lanes.
`timescale 1ns / 1ps
module qtg_horner_cell #(
	parameter int TIME_BITS = 10,
	parameter int W         = 118
) (
	input  logic clk,
	input  logic adv,
	input  logic [TIME_BITS-1:0] t_in,
	input  logic [qtg_pkg::LANES-1:0][W-1:0] acc_in,
	input  logic [qtg_pkg::LANES-1:0][W-1:0] coef,
	output logic [TIME_BITS-1:0] t_q,
	output logic [qtg_pkg::LANES-1:0][W-1:0] acc_q
);
	import qtg_pkg::*;

	logic signed [TIME_BITS:0] t_s;
	logic [LANES-1:0][W-1:0]   nxt;

	assign t_s = $signed({1'b0, t_in});

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			nxt[l] = W'($signed(acc_in[l]) * t_s) + coef[l];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_q   <= t_in;
			acc_q <= nxt;
		end
	end
endmodule

@@ src/qtg_div_cell.sv @@
// One restoring quotient bit of the scaled sums, all three lanes.
`timescale 1ns / 1ps
module qtg_div_cell #(
	parameter int DW  = 51,
	parameter int RW  = 83,
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic adv,
	input  logic [DW-1:0] den,
	input  logic [qtg_pkg::LANES-1:0][RW-1:0] rem_in,
	input  logic [qtg_pkg::LANES-1:0][qtg_pkg::QUO_BITS-1:0] quo_in,
	input  qtg_pkg::sat_t [qtg_pkg::LANES-1:0] sat_in,
	output logic [qtg_pkg::LANES-1:0][RW-1:0] rem_q,
	output logic [qtg_pkg::LANES-1:0][qtg_pkg::QUO_BITS-1:0] quo_q,
	output qtg_pkg::sat_t [qtg_pkg::LANES-1:0] sat_q
);
	import qtg_pkg::*;

	logic [RW-1:0]    shifted;
	logic [LANES-1:0] fit;

	assign shifted = RW'(den) << BIT;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			fit[l] = rem_in[l] >= shifted;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= fit[l] ? rem_in[l] - shifted : rem_in[l];
				quo_q[l] <= {quo_in[l][QUO_BITS-2:0], fit[l]};
			end
			sat_q <= sat_in;
		end
	end
endmodule

@@ src/quintic_trajectory_generator_unit.sv @@
// Top level: quintic trajectory sampler built from a row of pipeline cells.
`timescale 1ns / 1ps
// Usage
//   wr_en/wr_index/wr_data load the segment: 0 duration (ticks), 1..2 start/end
//   position, 3..4 start/end velocity, 5..6 start/end accel (signed Q16.16).
//   Write only while no sample is in flight. Each write restarts a
//   coefficient pass (one power of T per cycle through a shared Horner unit);
//   sample_in.ready stays low during it. Reset loads T = 1, all else 0, and
//   runs the same coefficient pass.
//   sample_in carries one tick word; traj_out returns position, speed,
//   accel_out and overflow for it, rounded to nearest and saturated.
// Timing
//   The row is 5 Horner cells in the tick, one range/offset stage,
//   then 32 divider cells, each resolving one quotient bit against 2*T^5.
//   Throughput is one word per cycle once the coefficient pass is done.
//   When traj_out stalls, each cell holds only while the cell after it is full,
//   so bubbles collapse and input keeps flowing until the row is full.
module quintic_trajectory_generator_unit #(
	parameter int TIME_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	qtg_time_if.sink   sample_in,
	qtg_traj_if.source traj_out,
	input  logic wr_en,
	input  logic [qtg_pkg::IDX_W-1:0] wr_index,
	input  logic [qtg_pkg::CFG_W-1:0] wr_data
);
	import qtg_pkg::*;

	localparam int W          = 7 * TIME_BITS + 48;  // scaled sums
	localparam int DW         = 5 * TIME_BITS + 1;   // 2*T^5
	localparam int RW         = DW + QUO_BITS;       // divider remainder
	localparam int PREP_STAGE = HORNER_CELLS + 1;
	localparam int STAGES     = HORNER_CELLS + 1 + QUO_BITS;

	logic                                     busy;
	logic [HORNER_CELLS:0][LANES-1:0][W-1:0] coef;
	logic [DW-1:0]                            den;

	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] adv;

	logic [TIME_BITS-1:0]    h_t   [HORNER_CELLS+1];
	logic [LANES-1:0][W-1:0] h_acc [HORNER_CELLS+1];

	logic [LANES-1:0][RW-1:0]       d_rem [QUO_BITS+1];
	logic [LANES-1:0][QUO_BITS-1:0] d_quo [QUO_BITS+1];
	sat_t [LANES-1:0]               d_sat [QUO_BITS+1];

	logic [LANES-1:0][RW-1:0] prep_rem_s6;
	sat_t [LANES-1:0]         prep_sat_s6;
	logic [LANES-1:0][RW-1:0] prep_rem;
	sat_t [LANES-1:0]         prep_sat;
	logic [W:0]               prep_y [LANES];

	logic [LANES-1:0][QUO_BITS-1:0] res;

	qtg_coef #(.TIME_BITS(TIME_BITS), .W(W), .DW(DW)) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.busy     (busy),
		.coef     (coef),
		.den      (den)
	);

	// a cell may load when it is empty or its successor loads this cycle
	always_comb begin
		adv[STAGES+1] = traj_out.ready;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign sample_in.ready = adv[1] && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= sample_in.valid && !busy;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Horner row: start from the leading coefficient, fold in one tick per cell
	assign h_t[0]   = sample_in.sample_time;
	assign h_acc[0] = coef[0];

	for (genvar k = 1; k <= HORNER_CELLS; k++) begin : g_horner
		qtg_horner_cell #(.TIME_BITS(TIME_BITS), .W(W)) u_cell (
			.clk    (clk),
			.adv    (adv[k]),
			.t_in   (h_t[k-1]),
			.acc_in (h_acc[k-1]),
			.coef   (coef[k]),
			.t_q    (h_t[k]),
			.acc_q  (h_acc[k])
		);
	end

	// Offset each sum by 2^31 * den so the floor quotient is a plain 32-bit
	// unsigned value; anything outside that window saturates.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prep_y[l]      = {h_acc[HORNER_CELLS][l][W-1], h_acc[HORNER_CELLS][l]}
				+ (W+1)'({den, 31'b0});
			prep_sat[l].lo = prep_y[l][W];
			prep_sat[l].hi = !prep_y[l][W] && (prep_y[l] >= (W+1)'({den, 32'b0}));
			prep_rem[l]    = prep_y[l][RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[PREP_STAGE]) begin
			prep_rem_s6 <= prep_rem;
			prep_sat_s6 <= prep_sat;
		end
	end

	assign d_rem[0] = prep_rem_s6;
	assign d_sat[0] = prep_sat_s6;
	assign d_quo[0] = '0;

	// divider row: most significant quotient bit first
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		qtg_div_cell #(.DW(DW), .RW(RW), .BIT(QUO_BITS - 1 - i)) u_cell (
			.clk    (clk),
			.adv    (adv[PREP_STAGE + 1 + i]),
			.den    (den),
			.rem_in (d_rem[i]),
			.quo_in (d_quo[i]),
			.sat_in (d_sat[i]),
			.rem_q  (d_rem[i+1]),
			.quo_q  (d_quo[i+1]),
			.sat_q  (d_sat[i+1])
		);
	end

	// drop the 2^31 offset by flipping the top bit, or clamp
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (d_sat[QUO_BITS][l].hi) begin
				res[l] = SAT_MAX;
			end else if (d_sat[QUO_BITS][l].lo) begin
				res[l] = SAT_MIN;
			end else begin
				res[l] = {~d_quo[QUO_BITS][l][QUO_BITS-1], d_quo[QUO_BITS][l][QUO_BITS-2:0]};
			end
		end
	end

	assign traj_out.valid     = vld_q[STAGES];
	assign traj_out.position  = res[LANE_POS];
	assign traj_out.speed     = res[LANE_SPD];
	assign traj_out.accel_out = res[LANE_ACC];
	assign traj_out.overflow  = |d_sat[QUO_BITS];

	a_write_restarts : assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> busy)
		else $error("register write did not restart the coefficient pass");

	a_no_take_while_busy : assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !sample_in.ready)
		else $error("sample taken during coefficient pass");

	a_last_drains : assert property (@(posedge clk) disable iff (!arst_n)
		(traj_out.valid && traj_out.ready && !vld_q[STAGES-1]) |=> !traj_out.valid)
		else $error("output word repeated after hand-off");
endmodule
